// ===== rtl/sorted_set_min_max_gap_defines.svh =====
// Assertion helpers used by the top-level RTL.
`ifndef SORTED_SET_MIN_MAX_GAP_DEFINES_SVH
`define SORTED_SET_MIN_MAX_GAP_DEFINES_SVH

// Check cons in the same cycle as ante.
`define SGAP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define SGAP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sgap_pkg.sv =====
`timescale 1ns / 1ps
package sgap_pkg;

  localparam int VAL_W  = 32;
  localparam int CNT_W  = 11;
  localparam int OUT_W  = 80;

  localparam logic [VAL_W-1:0] KEY_BIAS = 32'h8000_0000;
  localparam logic [VAL_W-1:0] GAP_INIT = 32'hFFFF_FFFF;
  localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  typedef struct packed {
    logic [VAL_W-1:0] longest_span;
    logic [VAL_W-1:0] shortest_span;
    logic             span_valid;
    logic [CNT_W-1:0] count;
    logic             status;
  } res_t;

endpackage

// ===== rtl/sgap_ram.sv =====
`timescale 1ns / 1ps
module sgap_ram
  import sgap_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [VAL_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [VAL_W-1:0] rdata
);

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sgap_ctrl.sv =====
`timescale 1ns / 1ps
module sgap_ctrl
  import sgap_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int CW    = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] cap,
  input  logic             start,
  input  logic [VAL_W-1:0] value,
  output logic             idle,
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res,
  output logic             ram_we,
  output logic [AW-1:0]    ram_waddr,
  output logic [VAL_W-1:0] ram_wdata,
  output logic             ram_re,
  output logic [AW-1:0]    ram_raddr,
  input  logic [VAL_W-1:0] ram_rdata
);

  localparam int WX = (CW > CNT_W) ? CW : CNT_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_PUT  = 5'b00100,
    S_UPD  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [VAL_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] prev_r, prev_nxt;
  logic [VAL_W-1:0] next_r, next_nxt;
  logic             has_prev_r, has_prev_nxt;
  logic             has_next_r, has_next_nxt;
  logic [VAL_W-1:0] gap_r, gap_nxt;
  logic [VAL_W-1:0] min_r, min_nxt;
  logic [VAL_W-1:0] max_r, max_nxt;
  logic             status_r, status_nxt;

  logic             space_ok;
  logic [VAL_W-1:0] key_in;
  logic [VAL_W-1:0] gap_lo;
  logic [VAL_W-1:0] gap_hi;
  logic [VAL_W-1:0] gap_a;
  logic [WX-1:0]    count_x;
  logic             valid;

  assign key_in   = value ^ KEY_BIAS;
  assign space_ok = ({1'b0, count_r} < (CW+1)'(DEPTH)) && (WX'(count_r) < WX'(cap));
  assign gap_lo   = key_r - prev_r;
  assign gap_hi   = next_r - key_r;
  assign gap_a    = (has_prev_r && (gap_lo < gap_r)) ? gap_lo : gap_r;

  // Entries shift up from the top; the write at idx and the read at idx-2
  // never touch the same entry, so no forwarding is needed.
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    key_nxt      = key_r;
    prev_nxt     = prev_r;
    next_nxt     = next_r;
    has_prev_nxt = has_prev_r;
    has_next_nxt = has_next_r;
    gap_nxt      = gap_r;
    min_nxt      = min_r;
    max_nxt      = max_r;
    status_nxt   = status_r;
    ram_we       = 1'b0;
    ram_waddr    = idx_r;
    ram_wdata    = key_r;
    ram_re       = 1'b0;
    ram_raddr    = idx_r - AW'(2);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          key_nxt      = key_in;
          has_prev_nxt = 1'b0;
          has_next_nxt = 1'b0;
          if (space_ok) begin
            status_nxt = ST_OK;
            if (count_r == '0) begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = key_in;
              state_nxt = S_UPD;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = AW'(count_r - CW'(1));
              idx_nxt   = AW'(count_r);
              state_nxt = S_SCAN;
            end
          end else begin
            status_nxt = ST_FULL;
            state_nxt  = S_FIN;
          end
        end
      end
      S_SCAN: begin
        ram_we = 1'b1;
        if (ram_rdata >= key_r) begin
          ram_wdata    = ram_rdata;
          next_nxt     = ram_rdata;
          has_next_nxt = 1'b1;
          idx_nxt      = idx_r - AW'(1);
          if (idx_r == AW'(1)) begin
            state_nxt = S_PUT;
          end else begin
            ram_re = 1'b1;
          end
        end else begin
          prev_nxt     = ram_rdata;
          has_prev_nxt = 1'b1;
          state_nxt    = S_UPD;
        end
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        count_nxt = count_r + CW'(1);
        if (!has_prev_r) begin
          min_nxt = key_r;
        end
        if (!has_next_r) begin
          max_nxt = key_r;
        end
        gap_nxt   = (has_next_r && (gap_hi < gap_a)) ? gap_hi : gap_a;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      gap_r   <= GAP_INIT;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      gap_r   <= gap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    key_r      <= key_nxt;
    prev_r     <= prev_nxt;
    next_r     <= next_nxt;
    has_prev_r <= has_prev_nxt;
    has_next_r <= has_next_nxt;
    min_r      <= min_nxt;
    max_r      <= max_nxt;
    status_r   <= status_nxt;
  end

  assign count_x   = WX'(count_r);
  assign valid     = count_x >= WX'(2);
  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_FIN);

  always_comb begin
    res.status        = status_r;
    res.count         = count_x[CNT_W-1:0];
    res.span_valid    = valid;
    res.shortest_span = valid ? gap_r : '0;
    res.longest_span  = valid ? (max_r - min_r) : '0;
  end

endmodule

// ===== rtl/sorted_set_min_max_gap.sv =====
`timescale 1ns / 1ps
// Sorted store of signed 32-bit values with shortest adjacent gap and longest
// span. Each input word inserts one value in ascending order (or is dropped
// with status full once the count reaches min(capacity, DEPTH)) and yields one
// result word. From its accept, an inserted value goes through these steps:
// the entries above its sorted position shift up one per cycle through the
// single read and single write port of the store memory, the value is written
// (where the scan meets a smaller entry, or at the bottom), the gap and span
// registers are updated, the result is handed to the output register and the
// engine returns to idle, where it can accept the next value. The first value
// into an empty store is written at the bottom with no scan, and a dropped
// value goes straight to the result; a result may wait for a full output
// register. The next input word is taken once the engine is idle again, while
// the previous result may still wait in the output register. Capacity must be
// written through the cfg channel only while the block is idle; the block
// itself does not enforce this. Capacity resets to 1024.
`include "sorted_set_min_max_gap_defines.svh"
module sorted_set_min_max_gap
  import sgap_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [VAL_W-1:0] in_tdata,   // value[31:0]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // status, count[10:0], span_valid,
                                       // shortest_span[31:0], longest_span[31:0], zero pad
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data    // capacity[10:0]
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] cap_r;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  logic             idle;
  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [VAL_W-1:0] ram_rdata;

  logic             in_fire;
  res_t             out_res;
  logic             out_span_ok;
  logic             out_spans_ok;
  logic             out_count_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  sgap_ram #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  sgap_ctrl #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .CW   (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cap      (cap_r),
    .start    (in_tvalid && in_tready),
    .value    (in_tdata),
    .idle     (idle),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata)
  );

  assign in_tready = idle;
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {(OUT_W - $bits(res_t))'(0), res};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign in_fire      = in_tvalid && in_tready;
  assign out_res      = res_t'(out_data_r[$bits(res_t)-1:0]);
  assign out_span_ok  = out_res.span_valid == (out_res.count >= CNT_W'(2));
  assign out_spans_ok = out_res.span_valid ||
                        ((out_res.shortest_span == '0) && (out_res.longest_span == '0));
  assign out_count_ok = (out_res.status != ST_OK) || (out_res.count != '0);

  `SGAP_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, !in_tready, "accepted while busy")
  `SGAP_ASSERT_NOW(a_span_valid_count, clk, rst_n, out_tvalid, out_span_ok, "span_valid off")
  `SGAP_ASSERT_NOW(a_spans_zero, clk, rst_n, out_tvalid, out_spans_ok, "spans not zero")
  `SGAP_ASSERT_NOW(a_ok_nonempty, clk, rst_n, out_tvalid, out_count_ok, "empty after accept")

endmodule

// ===== test/tb_sorted_set_min_max_gap.sv =====
`timescale 1ns / 1ps
module tb_sorted_set_min_max_gap;
  import sgap_pkg::*;

  localparam int STORE_DEPTH = 1024;
  localparam int STALL_LIMIT = 20000;
  localparam int RES_W       = $bits(res_t);

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [VAL_W-1:0] in_tdata;   // value[31:0]
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;  // status, count[10:0], span_valid,
                                // shortest_span[31:0], longest_span[31:0], zero pad
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data;   // capacity[10:0]

  // offset-binary keys, ascending, mirroring the store
  logic [VAL_W-1:0] held_keys[$];
  logic [CNT_W-1:0] capacity;
  res_t             pending_results[$];
  int               send_idle_pct;
  int               recv_idle_pct;
  int               mismatch_count = 0;
  int               stall_cycles = 0;

  sorted_set_min_max_gap #(
    .DEPTH(STORE_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic res_t track_value(logic [VAL_W-1:0] value);
    res_t             r;
    logic [VAL_W-1:0] key;
    logic [VAL_W-1:0] gap;
    int               pos;
    int               eff_cap;
    r = '0;
    key = value ^ KEY_BIAS;
    eff_cap = (capacity > STORE_DEPTH) ? STORE_DEPTH : int'(capacity);
    if (held_keys.size() < eff_cap) begin
      pos = 0;
      while (pos < held_keys.size() && held_keys[pos] < key) pos++;
      held_keys.insert(pos, key);
      r.status = ST_OK;
    end else begin
      r.status = ST_FULL;
    end
    r.count = CNT_W'(held_keys.size());
    if (held_keys.size() >= 2) begin
      r.span_valid = 1'b1;
      r.shortest_span = GAP_INIT;
      for (int i = 1; i < held_keys.size(); i++) begin
        gap = held_keys[i] - held_keys[i-1];
        if (gap < r.shortest_span) r.shortest_span = gap;
      end
      r.longest_span = held_keys[held_keys.size()-1] - held_keys[0];
    end
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int kind;
    kind = $urandom_range(99);
    if (kind < 40 || held_keys.size() == 0) return $urandom();
    if (kind < 60) return VAL_W'($urandom_range(16) - 8);
    if (kind < 75) return held_keys[$urandom_range(held_keys.size() - 1)] ^ KEY_BIAS;
    if (kind < 85) begin
      if ($urandom_range(1)) return 32'h7FFF_FFFF - $urandom_range(3);
      return 32'h8000_0000 + $urandom_range(3);
    end
    return (held_keys[$urandom_range(held_keys.size() - 1)] ^ KEY_BIAS)
           + $urandom_range(2) - 1;
  endfunction

  task automatic send_value(input logic [VAL_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(track_value(value));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CNT_W-1:0] cap);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    capacity = cap;
  endtask

  task automatic test_value_extremes();
    logic [VAL_W-1:0] values[$] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                    32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF,
                                    32'hFFFF_0000, 32'h8000_0000};
    foreach (values[i]) send_value(values[i]);
  endtask

  task automatic test_zero_capacity();
    set_capacity('0);
    repeat (3) send_value(pick_value());
  endtask

  task automatic test_capacity_below_count();
    set_capacity(CNT_W'(4));
    repeat (3) send_value($urandom());
  endtask

  task automatic test_random_inserts(input logic [CNT_W-1:0] cap, input int n_items,
                                     input int send_pct, input int recv_pct);
    set_capacity(cap);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (n_items) send_value(pick_value());
  endtask

  always @(posedge clk) begin
    res_t seen;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen = res_t'(out_tdata[RES_W-1:0]);
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result word %h", out_tdata);
      end else begin
        want = pending_results.pop_front();
        if (seen.status !== want.status || seen.count !== want.count ||
            seen.span_valid !== want.span_valid ||
            seen.shortest_span !== want.shortest_span ||
            seen.longest_span !== want.longest_span ||
            out_tdata[OUT_W-1:RES_W] !== '0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected st=%0d cnt=%0d v=%0d min=%h max=%h, ",
                     want.status, want.count, want.span_valid, want.shortest_span,
                     want.longest_span, "got st=%0d cnt=%0d v=%0d min=%h max=%h pad=%b",
                     seen.status, seen.count, seen.span_valid, seen.shortest_span,
                     seen.longest_span, out_tdata[OUT_W-1:RES_W]);
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_sorted_set_min_max_gap failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    capacity      = CAP_RESET;
    send_idle_pct = 33;
    recv_idle_pct = 68;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_value_extremes();
    test_zero_capacity();
    test_capacity_below_count();
    test_random_inserts(CNT_W'(150), 180, 33, 68);
    test_random_inserts(CNT_W'(360), 190, 68, 33);
    test_random_inserts('1, 190, 0, 0);
    drain_results();
    repeat (STORE_DEPTH + 8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_sorted_set_min_max_gap passed");
    end else begin
      $display("tb_sorted_set_min_max_gap failed");
    end
    $finish;
  end

endmodule
